>>> src/sdf_pkg.sv
// shared constants, descriptor type and bcd helper for the decimal field formatter
package sdf_pkg;

  // field width limits
  localparam int WIDTH_LIMIT = 64;
  localparam int MAX_CHARS   = 64;
  localparam int EFF_LIMIT   = (WIDTH_LIMIT < MAX_CHARS) ? WIDTH_LIMIT : MAX_CHARS;

  // widths
  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int POS_W      = 7;
  localparam int IDX_W      = $clog2(MAX_CHARS);
  localparam int CHAR_W     = 7;
  localparam int COUNT_W    = 16;

  // conversion takes two bits per cycle
  localparam int CONV_STEPS = VALUE_W / 2;
  localparam int ITER_W     = $clog2(CONV_STEPS);

  // descriptor queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // character codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'd43;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

  // flag bit positions
  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_SPACE = 2;
  localparam int FLAG_ZERO  = 3;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] bcd_t;

  // one field laid out as segment boundaries over the character position
  typedef struct packed {
    bcd_t             digits;
    logic             minus;
    logic [POS_W-1:0] lead_end;
    logic [POS_W-1:0] sign_end;
    logic [POS_W-1:0] zero_end;
    logic [POS_W-1:0] digit_end;
    logic [IDX_W-1:0] last_idx;
  } field_desc_t;

  // one double-dabble step: adjust digits, then shift in one binary bit
  function automatic bcd_t dabble_step(bcd_t bcd_in, logic bit_in);
    bcd_t                    adj;
    logic [4*NUM_DIGITS-1:0] flat;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_in[i] >= 4'd5) ? bcd_in[i] + 4'd3 : bcd_in[i];
    end
    flat = adj;
    flat = {flat[4*NUM_DIGITS-2:0], bit_in};
    return bcd_t'(flat);
  endfunction

endpackage

>>> src/sdf_front.sv
// front end: takes an item, converts the magnitude to bcd and plans the field layout
module sdf_front import sdf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [6:0]                min_width,
  input  logic [5:0]                min_digits,
  input  logic [3:0]                flag_bits,
  output logic                      q_push,
  input  logic                      q_full,
  output field_desc_t               q_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PLAN = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]         state;
  logic [ITER_W-1:0]  iter;
  logic [VALUE_W-1:0] bin;
  bcd_t               bcd;
  logic [POS_W-1:0]   width_sat;
  logic [5:0]         prec;
  logic [3:0]         flags;
  logic               neg;

  // planned counts
  logic [DIG_IDX_W:0] nd;
  logic [5:0]         pz;
  logic [POS_W-1:0]   pad;
  logic               has_sign;

  logic [DIG_IDX_W:0] nd_next;
  logic [5:0]         pz_next;
  logic [POS_W-1:0]   body;
  logic [POS_W-1:0]   pad_next;
  logic               accept;

  assign full   = (state != ST_IDLE);
  assign accept = push && !full;
  assign q_push = (state == ST_PUSH) && !q_full;

  // digit count, zero has one digit
  always_comb begin
    nd_next = (DIG_IDX_W+1)'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) nd_next = (DIG_IDX_W+1)'(i + 1);
    end
    pz_next  = (prec > 6'(nd_next)) ? prec - 6'(nd_next) : 6'd0;
    body     = POS_W'(nd_next) + POS_W'(pz_next) + POS_W'(neg || flags[FLAG_PLUS]);
    pad_next = (width_sat > body) ? width_sat - body : '0;
  end

  // segment layout from the planned counts
  always_comb begin
    logic             right_pad;
    logic             zfill;
    logic [POS_W-1:0] space_cnt;
    logic [POS_W-1:0] lead;
    logic [POS_W-1:0] zeros;
    logic [POS_W-1:0] trail;
    logic [POS_W-1:0] total;
    right_pad = !flags[FLAG_LEFT] && (pad != '0);
    zfill     = flags[FLAG_ZERO] && !flags[FLAG_PLUS];
    space_cnt = POS_W'(flags[FLAG_SPACE]);
    lead      = right_pad ? (zfill ? space_cnt : pad) : '0;
    zeros     = POS_W'(pz) + ((right_pad && zfill) ? pad - space_cnt : '0);
    trail     = flags[FLAG_LEFT] ? pad : '0;
    q_data.digits    = bcd;
    q_data.minus     = neg;
    q_data.lead_end  = lead;
    q_data.sign_end  = lead + POS_W'(has_sign);
    q_data.zero_end  = q_data.sign_end + zeros;
    q_data.digit_end = q_data.zero_end + POS_W'(nd);
    total            = q_data.digit_end + trail;
    if (total > POS_W'(MAX_CHARS)) total = POS_W'(MAX_CHARS);
    q_data.last_idx  = IDX_W'(total - POS_W'(1));
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
            iter  <= '0;
          end
        end
        ST_CONV: begin
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(CONV_STEPS - 1)) state <= ST_PLAN;
        end
        ST_PLAN: state <= ST_PUSH;
        ST_PUSH: begin
          if (!q_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: capture, two dabble steps per cycle, plan
  always_ff @(posedge clk) begin
    if (accept) begin
      bin       <= value[VALUE_W-1] ? VALUE_W'(0) - value : value;
      neg       <= value[VALUE_W-1];
      bcd       <= '0;
      width_sat <= (min_width > POS_W'(EFF_LIMIT)) ? POS_W'(EFF_LIMIT) : min_width;
      prec      <= min_digits;
      flags     <= flag_bits;
    end else if (state == ST_CONV) begin
      bin <= {bin[VALUE_W-3:0], 2'b00};
      bcd <= dabble_step(dabble_step(bcd, bin[VALUE_W-1]), bin[VALUE_W-2]);
    end
    if (state == ST_PLAN) begin
      nd       <= nd_next;
      pz       <= pz_next;
      pad      <= pad_next;
      has_sign <= neg || flags[FLAG_PLUS];
    end
  end

endmodule

>>> src/sdf_queue.sv
// short descriptor queue between front and back
module sdf_queue import sdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  field_desc_t wr_data,
  output logic        full,
  input  logic        rd_en,
  output field_desc_t rd_data,
  output logic        empty
);

  field_desc_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full    = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rd_en) rd_ptr <= rd_ptr + QPTR_W'(1);
      fill <= fill + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
    end
  end

endmodule

>>> src/sdf_back.sv
// back end: walks a field descriptor and emits one character per transfer
module sdf_back import sdf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  field_desc_t         q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [CHAR_W-1:0]   char_code,
  output logic                last_char,
  output logic [COUNT_W-1:0]  count_so_far
);

  logic                busy;
  field_desc_t         desc;
  logic [IDX_W-1:0]    pos;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic [COUNT_W-1:0]  out_count;
  logic [COUNT_W-1:0]  running;
  logic [COUNT_W-1:0]  running_next;
  logic [CHAR_W-1:0]   char_next;
  logic [POS_W-1:0]    pos_ext;
  logic [POS_W-1:0]    dig_idx;
  logic                adv;

  assign q_pop        = !busy && !q_empty;
  assign adv          = busy && (!out_valid || pop);
  assign empty        = !out_valid;
  assign char_code    = out_char;
  assign last_char    = out_last;
  assign count_so_far = out_count;

  assign running_next = (running == '1) ? running : running + COUNT_W'(1);

  // character at the current position
  always_comb begin
    pos_ext = POS_W'(pos);
    dig_idx = desc.digit_end - pos_ext - POS_W'(1);
    priority if (pos_ext < desc.lead_end) begin
      char_next = CH_SPACE;
    end else if (pos_ext < desc.sign_end) begin
      char_next = desc.minus ? CH_MINUS : CH_PLUS;
    end else if (pos_ext < desc.zero_end) begin
      char_next = CH_ZERO;
    end else if (pos_ext < desc.digit_end) begin
      char_next = CH_ZERO + CHAR_W'(desc.digits[dig_idx[DIG_IDX_W-1:0]]);
    end else begin
      char_next = CH_SPACE;
    end
  end

  // descriptor walk and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
      running   <= '0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (adv) begin
        pos <= pos + IDX_W'(1);
        if (pos == desc.last_idx) busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        running   <= running_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) desc <= q_data;
    if (adv) begin
      out_char  <= char_next;
      out_last  <= (pos == desc.last_idx);
      out_count <= running_next;
    end
  end

endmodule

>>> src/signed_decimal_field_formatter_top.sv
// top level of the signed decimal field formatter
//
// Input side is a queue: drive value, min_width, min_digits and flag_bits with
// push high; the transfer happens on a clock edge where full is low. Output
// side is a queue too: while empty is low, char_code, last_char and
// count_so_far show the oldest character, and pop high takes it. last_char
// marks the final character of a field; count_so_far counts characters since
// reset and holds at its maximum.
// The front converts the magnitude to decimal two bits per cycle, then plans
// the layout and pushes a descriptor; it takes no new item until that push is
// done. A two-entry descriptor queue decouples it from the back, which loads
// a descriptor, then emits one character per cycle while the receiver keeps
// popping. A field passes through conversion, planning, the queue, the back's
// descriptor load and its output register before its first character appears.
// Reset clears all control state and the character count. When the receiver
// stops popping, the output register holds, the back waits, the queue fills
// and full then stays high until space frees up; nothing is dropped.
module signed_decimal_field_formatter_top import sdf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [6:0]                min_width,
  input  logic [5:0]                min_digits,
  input  logic [3:0]                flag_bits,
  output logic                      empty,
  input  logic                      pop,
  output logic [CHAR_W-1:0]         char_code,
  output logic                      last_char,
  output logic [COUNT_W-1:0]        count_so_far
);

  field_desc_t front_desc;
  field_desc_t queue_desc;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;

  // decimal conversion and layout planning
  sdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .min_width  (min_width),
    .min_digits (min_digits),
    .flag_bits  (flag_bits),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_data     (front_desc)
  );

  // descriptor queue
  sdf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (front_desc),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (queue_desc),
    .empty   (q_empty)
  );

  // character emitter
  sdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (queue_desc),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .char_code    (char_code),
    .last_char    (last_char),
    .count_so_far (count_so_far)
  );

endmodule
